@@ rtl/group_quantized_int8_gemv_defines.svh @@
// Assertion macros shared by the group-quantised GEMV RTL.
// Each macro expects clk and rst_n in scope at the point of use.
`ifndef GROUP_QUANTIZED_INT8_GEMV_DEFINES_SVH
`define GROUP_QUANTIZED_INT8_GEMV_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GQG_ASSERT_IMPL(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define GQG_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

@@ rtl/gqg_pkg.sv @@
// Package for the group-quantised int8 GEMV column engine.
// Holds sizes, operation codes, control structs and the float32 helper functions.
`timescale 1ns / 1ps
`default_nettype none

package gqg_pkg;

    localparam int GROUP_LEN    = 32;
    localparam int LANES        = 8;
    localparam int MAX_GROUPS   = 8;
    localparam int CHUNKS       = GROUP_LEN / LANES;
    localparam int ROWS         = GROUP_LEN * MAX_GROUPS / LANES;
    localparam int ROW_W        = $clog2(ROWS);
    localparam int CHUNK_W      = $clog2(CHUNKS);
    localparam int GROUP_W      = $clog2(MAX_GROUPS);
    localparam int PROD_W       = 16;
    localparam int PART_W       = 21;
    localparam int GC_W         = 4;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

    typedef enum logic [1:0] {
        OP_ACT       = 2'd0,
        OP_ACT_SCALE = 2'd1,
        OP_COL_START = 2'd2,
        OP_WEIGHT    = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        FOP_NONE  = 3'd0,
        FOP_INIT  = 3'd1,
        FOP_SCALE = 3'd2,
        FOP_CONV  = 3'd3,
        FOP_TERM  = 3'd4,
        FOP_ACC   = 3'd5
    } fop_t;

    typedef logic [LANES-1:0][PROD_W-1:0] prod_vec_t;

    typedef struct packed {
        logic clear;
        logic accumulate;
    } merge_ctl_t;

    typedef struct packed {
        fop_t        op;
        logic [31:0] init_bits;
    } fpu_ctl_t;

    // Clamp the configured group count into 1..MAX_GROUPS
    function automatic logic [GC_W-1:0] groups_in_use(input logic [GC_W-1:0] gc);
        logic [GC_W-1:0] g;
        g = gc;
        if (g == '0)
            g = GC_W'(1);
        if (g > GC_W'(MAX_GROUPS))
            g = GC_W'(MAX_GROUPS);
        return g;
    endfunction

    // Exact conversion of the group's integer sum to float32
    function automatic logic [31:0] int_to_fp(input logic signed [PART_W-1:0] v);
        logic [PART_W-1:0] mag;
        logic [4:0]        k;
        logic [PART_W+22:0] sh;
        logic [7:0]        ex;
        if (v[PART_W-1])
            mag = PART_W'(-v);
        else
            mag = PART_W'(v);
        k = '0;
        for (int i = 0; i < PART_W; i++)
            if (mag[i])
                k = 5'(i);
        sh = (PART_W+23)'(mag) << (5'd23 - k);
        ex = 8'd127 + 8'(k);
        if (mag == '0)
            return 32'd0;
        return {v[PART_W-1], ex, sh[22:0]};
    endfunction

    // float32 multiply, round to nearest-even, subnormals kept
    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic               sr;
        logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [23:0]        ma, mb;
        logic [7:0]         ea, eb;
        logic [47:0]        p, n, x, mask;
        logic [5:0]         lz;
        logic signed [10:0] e;
        logic [7:0]         sh;
        logic [7:0]         exf;
        logic               st, inc;
        logic [30:0]        comb;
        sr     = a[31] ^ b[31];
        a_nan  = (&a[30:23]) && (|a[22:0]);
        b_nan  = (&b[30:23]) && (|b[22:0]);
        a_inf  = (&a[30:23]) && !(|a[22:0]);
        b_inf  = (&b[30:23]) && !(|b[22:0]);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
        ma = {|a[30:23], a[22:0]};
        mb = {|b[30:23], b[22:0]};
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        p  = 48'(ma) * 48'(mb);
        lz = '0;
        for (int i = 0; i < 48; i++)
            if (p[i])
                lz = 6'(47 - i);
        n = p << lz;
        e = 11'(ea) + 11'(eb) - 11'sd126 - 11'(lz);
        if (e >= 11'sd1) begin
            x   = n;
            st  = 1'b0;
            exf = e[7:0];
        end
        else begin
            sh   = (e < -11'sd46) ? 8'd48 : 8'(11'sd1 - e);
            x    = n >> sh;
            mask = ~({48{1'b1}} << sh);
            st   = |(n & mask);
            exf  = 8'd0;
        end
        inc  = x[23] & ((|x[22:0]) | st | x[24]);
        comb = {exf, x[46:24]} + 31'(inc);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero))
            return CANON_NAN;
        if (a_inf || b_inf)
            return {sr, 8'hFF, 23'd0};
        if (a_zero || b_zero)
            return {sr, 31'd0};
        if (e >= 11'sd255)
            return {sr, 8'hFF, 23'd0};
        return {sr, comb};
    endfunction

    // float32 add, round to nearest-even, subnormals kept
    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] xb, yb;
        logic        a_nan, b_nan, a_inf, b_inf, sub;
        logic [23:0] mx, my;
        logic [7:0]  ex, ey, d, dd;
        logic [26:0] ax, byf, by, bmask;
        logic [27:0] r;
        logic [26:0] rr;
        logic [4:0]  k, lzc, lim, shl;
        logic [8:0]  e, ef;
        logic        inc;
        logic [30:0] comb;
        a_nan = (&a[30:23]) && (|a[22:0]);
        b_nan = (&b[30:23]) && (|b[22:0]);
        a_inf = (&a[30:23]) && !(|a[22:0]);
        b_inf = (&b[30:23]) && !(|b[22:0]);
        if (b[30:0] > a[30:0]) begin
            xb = b;
            yb = a;
        end
        else begin
            xb = a;
            yb = b;
        end
        mx  = {|xb[30:23], xb[22:0]};
        my  = {|yb[30:23], yb[22:0]};
        ex  = (xb[30:23] == 8'd0) ? 8'd1 : xb[30:23];
        ey  = (yb[30:23] == 8'd0) ? 8'd1 : yb[30:23];
        d   = ex - ey;
        dd  = (d > 8'd27) ? 8'd27 : d;
        ax  = {mx, 3'b000};
        byf = {my, 3'b000};
        bmask = ~({27{1'b1}} << dd);
        by  = (byf >> dd) | 27'(|(byf & bmask));
        sub = xb[31] ^ yb[31];
        if (sub)
            r = {1'b0, ax} - {1'b0, by};
        else
            r = {1'b0, ax} + {1'b0, by};
        k = '0;
        for (int i = 0; i < 27; i++)
            if (r[i])
                k = 5'(i);
        lzc = 5'd26 - k;
        lim = 5'(ex - 8'd1 > 8'd26 ? 8'd26 : ex - 8'd1);
        shl = (lzc < lim) ? lzc : lim;
        if (r[27]) begin
            rr = {r[27:2], r[1] | r[0]};
            e  = 9'(ex) + 9'd1;
        end
        else begin
            rr = r[26:0] << shl;
            e  = 9'(ex) - 9'(shl);
        end
        ef   = rr[26] ? e : 9'd0;
        inc  = rr[2] & (rr[1] | rr[0] | rr[3]);
        comb = {ef[7:0], rr[25:3]} + 31'(inc);
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31])))
            return CANON_NAN;
        if (a_inf)
            return a;
        if (b_inf)
            return b;
        if (r == 28'd0)
            return {xb[31] & yb[31], 31'd0};
        if (ef >= 9'd255)
            return {xb[31], 8'hFF, 23'd0};
        return {xb[31], comb};
    endfunction

endpackage

`default_nettype wire

@@ rtl/gqg_lane.sv @@
// One multiply lane: registered int8 weight times int8 activation.
// Depends on gqg_pkg for the product width.
`timescale 1ns / 1ps
`default_nettype none

module gqg_lane (
    input  wire logic                          clk,
    input  wire logic                          enable,
    input  wire logic signed [7:0]             weight,
    input  wire logic signed [7:0]             activation,
    output logic signed [gqg_pkg::PROD_W-1:0]  product
);
    import gqg_pkg::*;

    logic signed [PROD_W-1:0] product_reg;

    // Capture the lane product
    always_ff @(posedge clk)
    begin
        if (enable)
        begin
            product_reg <= PROD_W'(weight) * PROD_W'(activation);
        end
    end

    assign product = product_reg;

endmodule

`default_nettype wire

@@ rtl/gqg_merge.sv @@
// Merging stage: adds the lane products into the group's exact integer sum.
// Depends on gqg_pkg for lane count, widths and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module gqg_merge (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire gqg_pkg::merge_ctl_t                 ctl,
    input  wire gqg_pkg::prod_vec_t                  products,
    output logic signed [gqg_pkg::PART_W-1:0]        partial
);
    import gqg_pkg::*;

    logic signed [PART_W-1:0] partial_reg;
    logic signed [PART_W-1:0] partial_next;
    logic signed [PART_W-1:0] lane_sum;

    // Sum the lanes
    always_comb
    begin
        lane_sum = '0;
        for (int l = 0; l < LANES; l++)
        begin
            lane_sum = lane_sum + PART_W'(signed'(products[l]));
        end
    end

    // Clear at a column or group boundary, otherwise add the chunk
    always_comb
    begin
        partial_next = partial_reg;
        if (ctl.clear)
        begin
            partial_next = '0;
        end
        else if (ctl.accumulate)
        begin
            partial_next = partial_reg + lane_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= '0;
        end
        else
        begin
            partial_reg <= partial_next;
        end
    end

    assign partial = partial_reg;

endmodule

`default_nettype wire

@@ rtl/gqg_fpu.sv @@
// Float32 group update unit: scale product, integer conversion, term, accumulate.
// Depends on gqg_pkg for the float helpers and the control struct.
`timescale 1ns / 1ps
`default_nettype none

module gqg_fpu (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire gqg_pkg::fpu_ctl_t             ctl,
    input  wire logic [31:0]                   act_scale,
    input  wire logic [31:0]                   wgt_scale,
    input  wire logic signed [gqg_pkg::PART_W-1:0] partial,
    output logic [31:0]                        acc_bits
);
    import gqg_pkg::*;

    logic [31:0] acc_reg;
    logic [31:0] scale_reg;
    logic [31:0] conv_reg;
    logic [31:0] term_reg;

    // Column accumulator: loaded at column start, updated once per group
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            case (ctl.op)
                FOP_INIT: acc_reg <= ctl.init_bits;
                FOP_ACC:  acc_reg <= fp_add(acc_reg, term_reg);
                default:  acc_reg <= acc_reg;
            endcase
        end
    end

    // One float operation per cycle, each result registered
    always_ff @(posedge clk)
    begin
        case (ctl.op)
            FOP_SCALE: scale_reg <= fp_mul(act_scale, wgt_scale);
            FOP_CONV:  conv_reg  <= int_to_fp(partial);
            FOP_TERM:  term_reg  <= fp_mul(conv_reg, scale_reg);
            default:   term_reg  <= term_reg;
        endcase
    end

    assign acc_bits = acc_reg;

endmodule

`default_nettype wire

@@ rtl/group_quantized_int8_gemv.sv @@
// Group-quantised int8 GEMV column engine. Load activations (eight per word) and one float32
// scale per group of 32, then open each column with its prior value and stream weight words.
// Activation, scale and column-start words are taken while idle; a weight word passes
// in turn through activation row read, eight lane multipliers and merge adder; the word
// closing a group then goes through the float32 update on one unit in turn (scale multiply,
// integer convert, term multiply, add), and the one closing the last group loads the output
// register, held there while the previous result still waits. One word is in work at a time.
`timescale 1ns / 1ps
`default_nettype none

`include "group_quantized_int8_gemv_defines.svh"

module group_quantized_int8_gemv (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [gqg_pkg::GC_W-1:0]    cfg_wdata,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [1:0]                  operation,
    input  wire logic signed [7:0]           value_0,
    input  wire logic signed [7:0]           value_1,
    input  wire logic signed [7:0]           value_2,
    input  wire logic signed [7:0]           value_3,
    input  wire logic signed [7:0]           value_4,
    input  wire logic signed [7:0]           value_5,
    input  wire logic signed [7:0]           value_6,
    input  wire logic signed [7:0]           value_7,
    input  wire logic [31:0]                 scale_bits,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [31:0]                      result_bits
);
    import gqg_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PROD  = 8'b0000_0010,
        ST_SUM   = 8'b0000_0100,
        ST_SCALE = 8'b0000_1000,
        ST_CONV  = 8'b0001_0000,
        ST_TERM  = 8'b0010_0000,
        ST_ACC   = 8'b0100_0000,
        ST_OUT   = 8'b1000_0000
    } state_t;

    state_t                  state_reg, state_next;
    logic [GC_W-1:0]         group_count_reg;
    logic [ROW_W-1:0]        load_row_reg;
    logic [GROUP_W-1:0]      scale_pos_reg;
    logic [CHUNK_W-1:0]      chunk_reg;
    logic [GROUP_W-1:0]      group_reg;
    logic                    out_valid_reg;
    logic [31:0]             result_reg;
    logic [LANES*8-1:0]      weight_reg;
    logic [LANES*8-1:0]      act_row_reg;
    logic [31:0]             wscale_reg;

    logic [LANES*8-1:0]      act_mem [ROWS];
    logic [31:0]             scale_mem [MAX_GROUPS];

    logic                    accept;
    op_t                     op;
    logic [LANES*8-1:0]      in_row;
    logic [ROW_W-1:0]        rd_row;
    logic                    last_group;
    logic                    out_load;
    merge_ctl_t              merge_ctl;
    fpu_ctl_t                fpu_ctl;
    prod_vec_t               products;
    logic signed [PART_W-1:0] partial;
    logic [31:0]             acc_bits;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign op       = op_t'(operation);
    assign in_row   = {value_7, value_6, value_5, value_4,
                       value_3, value_2, value_1, value_0};
    assign rd_row   = ROW_W'({group_reg, chunk_reg});
    assign last_group = ({1'b0, group_reg} + GC_W'(1)) >= groups_in_use(group_count_reg);
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    // Activation store, scale table, and capture of a weight word with its activation row
    always_ff @(posedge clk)
    begin
        if (accept && op == OP_ACT)
        begin
            act_mem[load_row_reg] <= in_row;
        end
        if (accept && op == OP_ACT_SCALE)
        begin
            scale_mem[scale_pos_reg] <= scale_bits;
        end
        if (accept && op == OP_WEIGHT)
        begin
            act_row_reg <= act_mem[rd_row];
            weight_reg  <= in_row;
            wscale_reg  <= scale_bits;
        end
    end

    // Sequence a word through the lanes, merge and float unit
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept && op == OP_WEIGHT) state_next = ST_PROD;
            ST_PROD:  state_next = ST_SUM;
            ST_SUM:   state_next = (chunk_reg == CHUNK_W'(CHUNKS - 1)) ? ST_SCALE : ST_IDLE;
            ST_SCALE: state_next = ST_CONV;
            ST_CONV:  state_next = ST_TERM;
            ST_TERM:  state_next = ST_ACC;
            ST_ACC:   state_next = last_group ? ST_OUT : ST_IDLE;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        merge_ctl.clear      = (accept && op == OP_COL_START) || (state_reg == ST_ACC);
        merge_ctl.accumulate = (state_reg == ST_SUM);
        fpu_ctl.init_bits    = scale_bits;
        fpu_ctl.op           = FOP_NONE;
        case (state_reg)
            ST_IDLE:  if (accept && op == OP_COL_START) fpu_ctl.op = FOP_INIT;
            ST_SCALE: fpu_ctl.op = FOP_SCALE;
            ST_CONV:  fpu_ctl.op = FOP_CONV;
            ST_TERM:  fpu_ctl.op = FOP_TERM;
            ST_ACC:   fpu_ctl.op = FOP_ACC;
            default:  fpu_ctl.op = FOP_NONE;
        endcase
    end

    // Control registers and positions
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            group_count_reg <= GC_W'(3);
            load_row_reg    <= '0;
            scale_pos_reg   <= '0;
            chunk_reg       <= '0;
            group_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                group_count_reg <= cfg_wdata;
            end
            if (accept)
            begin
                case (op)
                    OP_ACT:       load_row_reg  <= load_row_reg + ROW_W'(1);
                    OP_ACT_SCALE: scale_pos_reg <= scale_pos_reg + GROUP_W'(1);
                    OP_COL_START:
                    begin
                        load_row_reg  <= '0;
                        scale_pos_reg <= '0;
                        chunk_reg     <= '0;
                        group_reg     <= '0;
                    end
                    default:      chunk_reg <= chunk_reg;
                endcase
            end
            // Advance the chunk count once the word is merged
            if (state_reg == ST_SUM)
            begin
                chunk_reg <= chunk_reg + CHUNK_W'(1);
            end
            // Advance or wrap the group after the float update
            if (state_reg == ST_ACC)
            begin
                group_reg <= last_group ? '0 : group_reg + GROUP_W'(1);
            end
            // Hold the result until taken
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            result_reg <= acc_bits;
        end
    end

    // Lanes
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        gqg_lane u_lane (
            .clk        (clk),
            .enable     (state_reg == ST_PROD),
            .weight     (weight_reg[8*l +: 8]),
            .activation (act_row_reg[8*l +: 8]),
            .product    (products[l])
        );
    end

    gqg_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (merge_ctl),
        .products (products),
        .partial  (partial)
    );

    gqg_fpu u_fpu (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (fpu_ctl),
        .act_scale (scale_mem[group_reg]),
        .wgt_scale (wscale_reg),
        .partial   (partial),
        .acc_bits  (acc_bits)
    );

    assign out_valid   = out_valid_reg;
    assign result_bits = result_reg;

    `GQG_ASSERT_IMPL(a_state_onehot, 1'b1, $onehot(state_reg), "state not one-hot")
    `GQG_ASSERT_NEXT(a_weight_to_lanes, accept && op == OP_WEIGHT, state_reg == ST_PROD,
        "weight word did not reach the lanes")
    `GQG_ASSERT_NEXT(a_group_closed, state_reg == ST_ACC, chunk_reg == '0 && partial == '0,
        "group sum not cleared after update")
    `GQG_ASSERT_NEXT(a_out_loaded, out_load, out_valid_reg && result_reg == $past(acc_bits),
        "output register not loaded")

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for group_quantized_int8_gemv: drives activation, scale, column
// and weight words, predicts each column value in float32, compares every emitted word.
// Depends on gqg_pkg (operation codes, sizes) and the group_quantized_int8_gemv RTL.
`timescale 1ns / 1ps

// Tracks the engine state and holds the column values still to come out
class column_predictor;
    logic signed [7:0] act_store [gqg_pkg::GROUP_LEN * gqg_pkg::MAX_GROUPS];
    logic [31:0]       act_scale [gqg_pkg::MAX_GROUPS];
    logic [7:0]        load_pos;
    logic [2:0]        scale_pos;
    logic [1:0]        chunk_pos;
    logic [2:0]        group_pos;
    int                int_sum;
    logic [31:0]       col_acc;
    logic [3:0]        group_count;
    logic [31:0]       pending_columns [$];
    int                fail_count;

    function new();
        group_count = 4'd3;
        load_pos = '0;
        scale_pos = '0;
        chunk_pos = '0;
        group_pos = '0;
        int_sum = 0;
        col_acc = '0;
        fail_count = 0;
    endfunction

    // Widen float32 bits to a double, exactly
    function real f32_to_real(logic [31:0] b);
        real r;
        if (b[30:0] == 31'd0)
            return $bitstoreal({b[31], 63'd0});
        if (b[30:23] == 8'd0)
        begin
            r = $itor(b[22:0]) * (2.0 ** (-149));
            return b[31] ? -r : r;
        end
        if (b[30:23] == 8'hFF)
            return $bitstoreal({b[31], 11'h7FF, (b[22:0] != 0), 51'd0});
        return $bitstoreal({b[31], 11'({3'd0, b[30:23]}) + 11'd896, b[22:0], 29'd0});
    endfunction

    // Round a double to float32, nearest-even, subnormals kept, NaN made canonical
    function logic [31:0] real_to_f32(real r);
        logic [63:0] d;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          e;
        int          sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? gqg_pkg::CANON_NAN : {d[63], 8'hFF, 23'd0};
        if (d[62:52] == 11'd0)
            return {d[63], 31'd0};
        e = int'(d[62:52]) - 1023;
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60)
            return {d[63], 31'd0};
        kept = {11'd1, d[51:0]} >> sh;
        rem = {11'd1, d[51:0]} & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 64'd1;
        if (e < -126)
            return {d[63], kept[30:0]};
        if (kept[24])
        begin
            kept = kept >> 1;
            e = e + 1;
        end
        if (e + 127 >= 255)
            return {d[63], 8'hFF, 23'd0};
        return {d[63], 8'(e + 127), kept[22:0]};
    endfunction

    function bit is_nan(logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 0);
    endfunction

    function logic [31:0] f32_mul(logic [31:0] a, logic [31:0] b);
        if (is_nan(a) || is_nan(b))
            return gqg_pkg::CANON_NAN;
        return real_to_f32(f32_to_real(a) * f32_to_real(b));
    endfunction

    function logic [31:0] f32_add(logic [31:0] a, logic [31:0] b);
        if (is_nan(a) || is_nan(b))
            return gqg_pkg::CANON_NAN;
        return real_to_f32(f32_to_real(a) + f32_to_real(b));
    endfunction

    // Advance the state on one accepted word
    function void note_word(gqg_pkg::op_t op, logic [7:0][7:0] lanes, logic [31:0] sbits);
        logic [7:0]  base;
        logic [31:0] group_scale;
        logic [31:0] term;
        int          in_use;
        case (op)
            gqg_pkg::OP_ACT:
            begin
                for (int l = 0; l < 8; l++)
                    act_store[8'(load_pos + l)] = $signed(lanes[l]);
                load_pos = load_pos + 8'd8;
            end
            gqg_pkg::OP_ACT_SCALE:
            begin
                act_scale[scale_pos] = sbits;
                scale_pos = scale_pos + 3'd1;
            end
            gqg_pkg::OP_COL_START:
            begin
                col_acc = sbits;
                chunk_pos = '0;
                group_pos = '0;
                int_sum = 0;
                load_pos = '0;
                scale_pos = '0;
            end
            default:
            begin
                base = {group_pos, 5'd0} + {3'd0, chunk_pos, 3'd0};
                for (int l = 0; l < 8; l++)
                    int_sum += int'($signed(lanes[l])) * int'(act_store[8'(base + l)]);
                chunk_pos = chunk_pos + 2'd1;
                if (chunk_pos == 2'd0)
                begin
                    group_scale = f32_mul(act_scale[group_pos], sbits);
                    if (is_nan(group_scale))
                        term = gqg_pkg::CANON_NAN;
                    else
                        term = real_to_f32($itor(int_sum) * f32_to_real(group_scale));
                    col_acc = f32_add(col_acc, term);
                    int_sum = 0;
                    in_use = (group_count == 0) ? 1 :
                             (group_count > gqg_pkg::MAX_GROUPS) ? gqg_pkg::MAX_GROUPS :
                             int'(group_count);
                    if (int'(group_pos) + 1 >= in_use)
                    begin
                        group_pos = '0;
                        pending_columns.push_back(col_acc);
                    end
                    else
                        group_pos = group_pos + 3'd1;
                end
            end
        endcase
    endfunction

    // Compare one emitted column value with the oldest one due
    function void check_column(logic [31:0] got);
        logic [31:0] want;
        if (pending_columns.size() == 0)
        begin
            $display("%0t: unexpected column value, expected none, actual %h", $time, got);
            fail_count++;
            return;
        end
        want = pending_columns.pop_front();
        if (got !== want)
        begin
            $display("%0t: result_bits mismatch, expected %h, actual %h", $time, want, got);
            fail_count++;
        end
    endfunction
endclass

module testbench;
    import gqg_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 24;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [GC_W-1:0]   cfg_wdata;
    logic              in_valid;
    logic              in_ready;
    logic [1:0]        operation;
    logic [7:0][7:0]   lanes;
    logic [31:0]       scale_bits;
    logic              out_valid;
    logic              out_ready;
    logic [31:0]       result_bits;

    column_predictor predictor;
    int              cycles;
    int              words_sent;
    int              burst_left;
    int              groups_now;

    group_quantized_int8_gemv dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .value_0     (lanes[0]),
        .value_1     (lanes[1]),
        .value_2     (lanes[2]),
        .value_3     (lanes[3]),
        .value_4     (lanes[4]),
        .value_5     (lanes[5]),
        .value_6     (lanes[6]),
        .value_7     (lanes[7]),
        .scale_bits  (scale_bits),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_bits (result_bits)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hold the run to a cycle budget
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Receiver stall pattern: free running, regular stalls, coin flip, long holds
    always @(negedge clk)
    begin
        case ((cycles / 96) % 4)
            0: out_ready <= 1'b1;
            1: out_ready <= (cycles % 4) != 0;
            2: out_ready <= $urandom_range(0, 1);
            default: out_ready <= (cycles % 16) >= 10;
        endcase
    end

    // Check every column word taken
    always @(posedge clk)
        if (rst_n && out_valid && out_ready)
            predictor.check_column(result_bits);

    function automatic logic [31:0] rand_float();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return {1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)};
        if (pick < 82)
            return $urandom;
        case ($urandom_range(0, 7))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7F80_0000;
            3: return 32'hFF80_0000;
            4: return 32'h7FC0_0001;
            5: return 32'h0000_0001;
            6: return 32'h7F7F_FFFF;
            default: return 32'h0080_0000;
        endcase
    endfunction

    function automatic logic [7:0][7:0] rand_lanes();
        logic [7:0][7:0] v;
        v = {$urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            for (int l = 0; l < 8; l++)
                v[l] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
        return v;
    endfunction

    // Send one word, with bursts and gaps, and note it once taken
    task automatic send_word(op_t op, logic [7:0][7:0] v, logic [31:0] s);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        operation <= op;
        lanes <= v;
        scale_bits <= s;
        do
            @(posedge clk);
        while (!in_ready);
        predictor.note_word(op, v, s);
        words_sent++;
    endtask

    // Drop valid and wait until every column due has come out
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (predictor.pending_columns.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic set_groups(int g);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= GC_W'(g);
        @(negedge clk);
        cfg_we <= 1'b0;
        predictor.group_count = GC_W'(g);
        groups_now = (g == 0) ? 1 : (g > MAX_GROUPS) ? MAX_GROUPS : g;
    endtask

    // One well-formed column, sometimes with extra words past its end
    task automatic send_column();
        send_word(OP_COL_START, rand_lanes(), rand_float());
        for (int i = 0; i < groups_now * CHUNKS; i++)
            send_word(OP_WEIGHT, rand_lanes(), rand_float());
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 6))
                send_word(OP_WEIGHT, rand_lanes(), rand_float());
    endtask

    task automatic random_phase(int words);
        int stop_at;
        int pick;
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                send_column();
            else if (pick < 82)
            begin
                // Rewind and reload activation rows and group scales
                send_word(OP_COL_START, rand_lanes(), rand_float());
                repeat ($urandom_range(1, 32))
                    send_word(OP_ACT, rand_lanes(), 32'd0);
                repeat ($urandom_range(1, 8))
                    send_word(OP_ACT_SCALE, rand_lanes(), rand_float());
            end
            else
                repeat ($urandom_range(1, 6))
                    send_word(op_t'($urandom_range(0, 3)), rand_lanes(), rand_float());
        end
    endtask

    initial
    begin
        predictor = new();
        cycles = 0;
        words_sent = 0;
        burst_left = 0;
        groups_now = 3;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        operation = OP_ACT;
        lanes = '0;
        scale_bits = '0;
        out_ready = 1'b0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Fill the whole activation store and every scale so no read sees an unwritten entry
        send_word(OP_ACT, {8{8'h80}}, 32'd0);
        send_word(OP_ACT, {8{8'h7F}}, 32'd0);
        for (int i = 2; i < ROWS; i++)
            send_word(OP_ACT, rand_lanes(), 32'd0);
        send_word(OP_ACT_SCALE, lanes, 32'h3F80_0000);
        send_word(OP_ACT_SCALE, lanes, 32'h7F7F_FFFF);
        send_word(OP_ACT_SCALE, lanes, 32'h0000_0001);
        for (int i = 3; i < MAX_GROUPS; i++)
            send_word(OP_ACT_SCALE, lanes, rand_float());

        // Extreme weights at the reset group count, then a NaN and an infinite group scale
        send_word(OP_COL_START, lanes, 32'd0);
        send_word(OP_WEIGHT, {8{8'h80}}, 32'd0);
        send_word(OP_WEIGHT, {8{8'h7F}}, 32'd0);
        send_word(OP_WEIGHT, {8{8'h80}}, 32'd0);
        send_word(OP_WEIGHT, {8{8'h7F}}, 32'h3F80_0000);
        for (int i = 0; i < 4; i++)
            send_word(OP_WEIGHT, {8{8'h80}}, 32'h7FC0_0000);
        for (int i = 0; i < 4; i++)
            send_word(OP_WEIGHT, {8{8'h7F}}, 32'h7F80_0000);
        // Carry on past the emitted value without a new column
        for (int i = 0; i < 12; i++)
            send_word(OP_WEIGHT, rand_lanes(), 32'h3F00_0000);

        random_phase(150);
        set_groups(1);
        random_phase(150);
        // Hold off until the engine has emptied, then resume mid-phase
        drain();
        random_phase(50);
        set_groups(8);
        random_phase(150);
        set_groups(0);
        random_phase(120);
        set_groups(15);
        random_phase(150);
        set_groups(5);
        random_phase(150);
        set_groups($urandom_range(1, 8));
        random_phase(150);

        drain();
        if (predictor.fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
